// ===== rtl/core/clsrng_pkg.sv =====
`timescale 1ns / 1ps

package clsrng_pkg;

    // field widths
    localparam int DATA_W  = 31;
    localparam int MUL_W   = 16;
    localparam int FOLD_W  = 8;
    localparam int PROD_W  = DATA_W + MUL_W;
    localparam int TDATA_W = 32;

    // default shuffle table depth
    localparam int TABLE_DEPTH = 32;

    // generator constants, both moduli are 2^31 minus a small fold constant
    localparam logic [DATA_W-1:0] MOD_ONE        = 31'd2147483563;
    localparam logic [DATA_W-1:0] MOD_TWO        = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_ONE        = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_TWO        = 16'd40692;
    localparam logic [FOLD_W-1:0] FOLD_ONE       = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD_TWO       = 8'd249;
    localparam logic [DATA_W-1:0] OUT_MAX        = 31'd2147483562;
    localparam logic [DATA_W-1:0] SEED_TWO_RESET = 31'd123456789;

    // input word kinds carried on tuser
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_WARM_MUL,
        S_WARM_FOLD,
        S_WARM_FIX,
        S_DRAW_MUL,
        S_DRAW_FOLD,
        S_DRAW_FIX,
        S_DRAW_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_seed;
        logic fix_one;
        logic fix_two;
        logic warm_write;
        logic cnt_dec;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic gen1_zero;
        logic cnt_zero;
        logic out_busy;
    } t_status;

endpackage

// ===== rtl/core/clsrng_ctrl.sv =====
`timescale 1ns / 1ps

module clsrng_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic                 i_opcode,
    input  clsrng_pkg::t_status  i_status,
    output clsrng_pkg::t_cmd     o_cmd
);

    clsrng_pkg::t_state r_state;
    clsrng_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clsrng_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            clsrng_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    if (i_opcode == clsrng_pkg::OP_RESEED || i_status.gen1_zero) begin
                        n_state = clsrng_pkg::S_SEED;
                    end else begin
                        n_state = clsrng_pkg::S_DRAW_MUL;
                    end
                end
            end
            clsrng_pkg::S_SEED: begin
                o_cmd.load_seed = 1'b1;
                n_state         = clsrng_pkg::S_WARM_MUL;
            end
            clsrng_pkg::S_WARM_MUL: begin
                n_state = clsrng_pkg::S_WARM_FOLD;
            end
            clsrng_pkg::S_WARM_FOLD: begin
                n_state = clsrng_pkg::S_WARM_FIX;
            end
            clsrng_pkg::S_WARM_FIX: begin
                o_cmd.fix_one    = 1'b1;
                o_cmd.warm_write = 1'b1;
                if (i_status.cnt_zero) begin
                    n_state = clsrng_pkg::S_DRAW_MUL;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = clsrng_pkg::S_WARM_MUL;
                end
            end
            clsrng_pkg::S_DRAW_MUL: begin
                n_state = clsrng_pkg::S_DRAW_FOLD;
            end
            clsrng_pkg::S_DRAW_FOLD: begin
                n_state = clsrng_pkg::S_DRAW_FIX;
            end
            clsrng_pkg::S_DRAW_FIX: begin
                o_cmd.fix_one = 1'b1;
                o_cmd.fix_two = 1'b1;
                n_state       = clsrng_pkg::S_DRAW_OUT;
            end
            clsrng_pkg::S_DRAW_OUT: begin
                // hold until the output register can take the word
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = clsrng_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clsrng_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/clsrng_dpath.sv =====
`timescale 1ns / 1ps

module clsrng_dpath #(
    parameter int TABLE_DEPTH = clsrng_pkg::TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  clsrng_pkg::t_cmd                i_cmd,
    output clsrng_pkg::t_status             o_status,
    input  logic                            i_opcode,
    input  logic [clsrng_pkg::DATA_W-1:0]   i_seed,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [clsrng_pkg::DATA_W-1:0]   o_value
);

    localparam int    DW      = clsrng_pkg::DATA_W;
    localparam int    PW      = clsrng_pkg::PROD_W;
    localparam int    SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int    CW      = $clog2(TABLE_DEPTH + 8);
    localparam int    QW      = $clog2(TABLE_DEPTH + 2);
    localparam longint BUCKET = 1 + longint'(clsrng_pkg::OUT_MAX) / TABLE_DEPTH;
    localparam longint RECIP  = (64'd1 << 32) / BUCKET;
    localparam int    RW      = $clog2(RECIP + 1);

    logic [DW-1:0]     r_seed;
    logic [DW-1:0]     r_gen1;
    logic [DW-1:0]     r_gen2;
    logic [DW-1:0]     r_out;
    logic [PW-1:0]     r_prod1;
    logic [PW-1:0]     r_prod2;
    logic [DW:0]       r_fold1;
    logic [DW:0]       r_fold2;
    logic [CW-1:0]     r_cnt;
    logic [QW-1:0]     r_qest;
    logic [DW-1:0]     r_rem;
    logic [SLOT_W-1:0] r_slot;
    logic [DW-1:0]     r_rd;
    logic [DW-1:0]     r_res;
    logic              r_valid;
    logic [DW-1:0]     mem [TABLE_DEPTH];

    logic [DW:0]       w_fix1;
    logic [DW:0]       w_fix2;
    logic [DW-1:0]     w_gen1_next;
    logic [DW-1:0]     w_gen2_next;
    logic [DW+RW-1:0]  w_qprod;
    logic [QW-1:0]     w_slot_full;
    logic [SLOT_W-1:0] w_slot;
    logic [DW-1:0]     w_base;
    logic [DW-1:0]     w_diff;
    logic              w_in_table;
    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [DW-1:0]     w_wdata;

    // capture the seed of an accepted word, zero and forced reseeds use one
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            if (i_opcode == clsrng_pkg::OP_RESEED && i_seed != '0) begin
                r_seed <= i_seed;
            end else begin
                r_seed <= DW'(1);
            end
        end
    end

    // modular multiply, stage one: constant product
    always_ff @(posedge i_clk) begin
        r_prod1 <= PW'(r_gen1) * PW'(clsrng_pkg::MUL_ONE);
        r_prod2 <= PW'(r_gen2) * PW'(clsrng_pkg::MUL_TWO);
    end

    // stage two: fold the bits above 2^31 back in
    always_ff @(posedge i_clk) begin
        r_fold1 <= (DW+1)'(r_prod1[DW-1:0])
                 + (DW+1)'(r_prod1[PW-1:DW]) * (DW+1)'(clsrng_pkg::FOLD_ONE);
        r_fold2 <= (DW+1)'(r_prod2[DW-1:0])
                 + (DW+1)'(r_prod2[PW-1:DW]) * (DW+1)'(clsrng_pkg::FOLD_TWO);
    end

    // stage three: one conditional subtract of the modulus
    always_comb begin
        w_fix1 = (r_fold1 >= {1'b0, clsrng_pkg::MOD_ONE})
               ? r_fold1 - {1'b0, clsrng_pkg::MOD_ONE} : r_fold1;
        w_fix2 = (r_fold2 >= {1'b0, clsrng_pkg::MOD_TWO})
               ? r_fold2 - {1'b0, clsrng_pkg::MOD_TWO} : r_fold2;
    end
    assign w_gen1_next = w_fix1[DW-1:0];
    assign w_gen2_next = w_fix2[DW-1:0];

    // generator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen1 <= '0;
            r_gen2 <= clsrng_pkg::SEED_TWO_RESET;
        end else if (i_cmd.load_seed) begin
            r_gen1 <= r_seed;
            r_gen2 <= r_seed;
        end else begin
            if (i_cmd.fix_one) begin
                r_gen1 <= w_gen1_next;
            end
            if (i_cmd.fix_two) begin
                r_gen2 <= w_gen2_next;
            end
        end
    end

    // warm-up step counter, counts down to zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_cnt <= CW'(TABLE_DEPTH + 7);
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end
    assign w_in_table = (r_cnt < CW'(TABLE_DEPTH));

    // slot = out / bucket: reciprocal estimate, then one correction
    assign w_qprod = (DW+RW)'(r_out) * (DW+RW)'(RECIP);
    always_ff @(posedge i_clk) begin
        r_qest <= QW'(w_qprod >> 32);
        r_rem  <= r_out - DW'(r_qest) * DW'(BUCKET);
    end
    assign w_slot_full = r_qest + QW'(r_rem >= DW'(BUCKET));
    assign w_slot = (w_slot_full >= QW'(TABLE_DEPTH))
                  ? SLOT_W'(TABLE_DEPTH - 1) : w_slot_full[SLOT_W-1:0];

    // table write port: warm-up fill or draw update
    assign w_we    = (i_cmd.warm_write && w_in_table) || i_cmd.commit;
    assign w_waddr = i_cmd.commit ? r_slot : r_cnt[SLOT_W-1:0];
    assign w_wdata = i_cmd.commit ? r_gen1 : w_gen1_next;

    // shuffle table
    always_ff @(posedge i_clk) begin
        r_rd <= mem[w_slot];
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= w_slot;
    end

    // table entry minus generator two, wrapped into 1..OUT_MAX
    assign w_base = r_rd - r_gen2;
    assign w_diff = (r_rd > r_gen2) ? w_base : w_base + clsrng_pkg::OUT_MAX;

    // shuffle output state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (i_cmd.commit) begin
            r_out <= w_diff;
        end else if (i_cmd.warm_write && r_cnt == '0) begin
            r_out <= w_gen1_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res <= w_diff;
        end
    end

    assign o_m_tvalid         = r_valid;
    assign o_value            = r_res;
    assign o_status.gen1_zero = (r_gen1 == '0);
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.out_busy  = r_valid && !i_m_tready;

endmodule

// ===== rtl/core/combined_lcg_shuffle_rng.sv =====
`timescale 1ns / 1ps

// Uniform random integer generator: two multiplicative congruential generators
// (40014 mod 2147483563 and 40692 mod 2147483399) combined through a shuffle
// table of TABLE_DEPTH entries. Each input word is a draw (tuser 0) or a reseed
// from the seed in tdata (tuser 1); every word returns one value in
// 1..2147483562. A draw runs the modular multiply (product, fold, subtract),
// then the registered table read and the combine step. A reseed, and the
// first draw after reset, first run the warm-up of generator one, which
// reuses the same multiply unit. The block takes one word at a time; the
// output register lets the next word be accepted while the last value waits
// on the master side.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = clsrng_pkg::TABLE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [clsrng_pkg::TDATA_W-1:0]     i_s_tdata,   // seed[30:0], pad
    input  logic                               i_s_tuser,   // opcode
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [clsrng_pkg::TDATA_W-1:0]     o_m_tdata    // random_value[30:0], pad
);

    clsrng_pkg::t_cmd                w_cmd;
    clsrng_pkg::t_status             w_status;
    logic [clsrng_pkg::DATA_W-1:0]   w_value;

    // sequencer
    clsrng_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_opcode   (i_s_tuser),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // generators, shuffle table and output register
    clsrng_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_opcode   (i_s_tuser),
        .i_seed     (i_s_tdata[clsrng_pkg::DATA_W-1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_value    (w_value)
    );

    assign o_m_tdata = {1'b0, w_value};

endmodule
